[sv/round_robin_ready_queue_macros.svh]
`ifndef ROUND_ROBIN_READY_QUEUE_MACROS_SVH
`define ROUND_ROBIN_READY_QUEUE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define RRQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rrq assertion failed");

// invariant that holds on every clock edge outside reset
`define RRQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rrq invariant failed");

`endif

[sv/rrq_pkg.sv]
`timescale 1ns / 1ps

package rrq_pkg;

    localparam int MAX_TASKS_DEF  = 32;
    localparam int SLICE_BITS_DEF = 16;

    localparam int TASK_ID_W = 5;
    localparam int CFG_W     = 16;

    localparam logic [CFG_W-1:0] SLICE_RESET = 16'd100;

    // item kinds
    localparam logic [2:0] KIND_ENQ   = 3'd0;
    localparam logic [2:0] KIND_DEQ   = 3'd1;
    localparam logic [2:0] KIND_YIELD = 3'd2;
    localparam logic [2:0] KIND_TICK  = 3'd3;
    localparam logic [2:0] KIND_PICK  = 3'd4;

    // result status
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_NOT_QUEUED = 3'd2;
    localparam logic [2:0] ST_ALREADY    = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;

    // queue cell operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_MOVE   = 2'd3;

    typedef logic [TASK_ID_W-1:0] t_task_id;

    typedef struct packed {
        logic [2:0] kind;
        t_task_id   task_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        t_task_id    head_task;
        logic        reschedule;
        logic [5:0]  queued_count;
        logic [15:0] slice_left;
    } t_out_item;

    typedef struct packed {
        logic [1:0] op;
        t_task_id   target;
    } t_cell_ctl;

endpackage

[sv/rrq_cell.sv]
`timescale 1ns / 1ps

module rrq_cell import rrq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_occ,
    input  logic      i_prev_hit,
    input  t_task_id  i_next_id,
    input  logic      i_next_occ,
    output t_task_id  o_id,
    output logic      o_occ,
    output logic      o_hit
);

    t_task_id r_id;
    logic     r_occ;
    t_task_id n_id;
    logic     n_occ;

    // hit ripples toward the tail: this cell and all behind the match shift
    assign o_hit = i_prev_hit | (r_occ && (r_id == i_ctl.target));
    assign o_id  = r_id;
    assign o_occ = r_occ;

    always_comb begin
        n_id  = r_id;
        n_occ = r_occ;
        case (i_ctl.op)
            OP_APPEND: begin
                if (!r_occ && i_prev_occ) begin
                    n_id  = i_ctl.target;
                    n_occ = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (o_hit) begin
                    n_id  = i_next_id;
                    n_occ = i_next_occ;
                end
            end
            OP_MOVE: begin
                if (o_hit) begin
                    // last occupied cell takes the moved task
                    if (r_occ && !i_next_occ) begin
                        n_id = i_ctl.target;
                    end else begin
                        n_id  = i_next_id;
                        n_occ = i_next_occ;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

[sv/rrq_slice_mem.sv]
`timescale 1ns / 1ps

module rrq_slice_mem import rrq_pkg::*; #(
    parameter int DEPTH = MAX_TASKS_DEF,
    parameter int WIDTH = SLICE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // an entry never written reads as zero
    assign o_rdata = r_rvalid ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rvalid  <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            if (i_rd) begin
                r_rvalid <= r_written[i_raddr];
            end
        end
    end

endmodule

[sv/round_robin_ready_queue.sv]
`timescale 1ns / 1ps
// Round-robin ready queue with per-task time slices. Items are enqueue, dequeue, yield,
// tick and pick; each gives one result with status, queue head, count, reschedule flag
// and the named task's remaining slice. The ready queue is a row of cells, one per
// queue position, that shift toward the head all at once when a task leaves or
// rotates; the slices live in a table with one read and at most one write per item.
// An item goes from acceptance to a registered result through accept with table read,
// queue and table update, and result load; a new item is taken only once the result is
// loaded, which waits while the output side stalls. The table read is registered and the
// cells update in one step. The next item is taken while a result still waits at the output.
// slice_length may be written only while no item is in flight.

module round_robin_ready_queue import rrq_pkg::*; #(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int SLICE_BITS = SLICE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

`include "round_robin_ready_queue_macros.svh"

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [SLICE_BITS-1:0] r_slice_len;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [MAX_TASKS-1:0]  r_qflag;
    logic [2:0]            r_kind;
    t_task_id              r_task;
    logic [2:0]            r_status;
    logic [2:0]            n_status;
    logic                  r_resched;
    logic                  n_resched;
    logic [SLICE_BITS-1:0] r_slice_out;
    logic [SLICE_BITS-1:0] n_slice_out;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_accept;
    logic                  w_load_out;
    logic [IDX_W-1:0]      w_idx;
    logic                  w_id_ok;
    logic                  w_queued;
    logic [SLICE_BITS-1:0] w_slice;
    logic                  w_we;
    logic [SLICE_BITS-1:0] w_wdata;
    logic                  w_set_flag;
    logic                  w_clr_flag;
    t_cell_ctl             w_ctl;
    logic [IDX_W-1:0]      w_raddr;

    t_task_id              w_id [MAX_TASKS+1];
    logic [MAX_TASKS:0]    w_occ;
    logic [MAX_TASKS-1:0]  w_hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_idx   = IDX_W'(r_task);
    assign w_id_ok = (32'(r_task) < 32'(MAX_TASKS));
    assign w_queued = w_id_ok && r_qflag[w_idx];

    // pick reads the head task's slice, every other kind the named task's
    assign w_raddr = (i_in_item.kind == KIND_PICK) ? IDX_W'(w_id[0])
                                                   : IDX_W'(i_in_item.task_id);

    rrq_slice_mem #(
        .DEPTH (MAX_TASKS),
        .WIDTH (SLICE_BITS)
    ) u_slice_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_slice),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata)
    );

    assign w_id[MAX_TASKS]  = '0;
    assign w_occ[MAX_TASKS] = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic prev_occ;
        logic prev_hit;
        if (g == 0) begin : g_first
            assign prev_occ = 1'b1;
            assign prev_hit = 1'b0;
        end else begin : g_rest
            assign prev_occ = w_occ[g-1];
            assign prev_hit = w_hit[g-1];
        end
        rrq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev_occ (prev_occ),
            .i_prev_hit (prev_hit),
            .i_next_id  (w_id[g+1]),
            .i_next_occ (w_occ[g+1]),
            .o_id       (w_id[g]),
            .o_occ      (w_occ[g]),
            .o_hit      (w_hit[g])
        );
    end

    always_comb begin
        n_status    = ST_OK;
        n_resched   = 1'b0;
        n_slice_out = w_slice;
        n_count     = r_count;
        w_we        = 1'b0;
        w_wdata     = w_slice;
        w_set_flag  = 1'b0;
        w_clr_flag  = 1'b0;
        w_ctl.op    = OP_NONE;
        w_ctl.target = r_task;
        if (r_state == S_EXEC) begin
            if (r_kind == KIND_PICK) begin
                if (r_count == '0) begin
                    n_status    = ST_EMPTY;
                    n_slice_out = '0;
                end
            end else if (!w_id_ok) begin
                n_slice_out = '0;
                if (r_kind <= KIND_TICK) begin
                    n_status = ST_NOT_QUEUED;
                end
            end else begin
                case (r_kind)
                    KIND_ENQ: begin
                        if (w_queued) begin
                            n_status = ST_ALREADY;
                        end else if (r_count == CNT_W'(MAX_TASKS)) begin
                            n_status = ST_FULL;
                        end else begin
                            if (w_slice == '0) begin
                                w_we        = 1'b1;
                                w_wdata     = r_slice_len;
                                n_slice_out = r_slice_len;
                            end
                            w_ctl.op   = OP_APPEND;
                            w_set_flag = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    KIND_DEQ: begin
                        if (!w_queued) begin
                            n_status = ST_NOT_QUEUED;
                        end else begin
                            w_ctl.op   = OP_REMOVE;
                            w_clr_flag = 1'b1;
                            n_count    = r_count - CNT_W'(1);
                        end
                    end
                    KIND_YIELD: begin
                        if (!w_queued) begin
                            n_status = ST_NOT_QUEUED;
                        end else if (r_count > CNT_W'(1)) begin
                            w_ctl.op = OP_MOVE;
                        end
                    end
                    KIND_TICK: begin
                        if (!w_queued) begin
                            n_status = ST_NOT_QUEUED;
                        end else if (w_slice > SLICE_BITS'(1)) begin
                            w_we        = 1'b1;
                            w_wdata     = w_slice - SLICE_BITS'(1);
                            n_slice_out = w_slice - SLICE_BITS'(1);
                        end else begin
                            // slice expired: reload, rotate when others wait
                            w_we        = 1'b1;
                            w_wdata     = r_slice_len;
                            n_slice_out = r_slice_len;
                            if (r_count > CNT_W'(1)) begin
                                w_ctl.op  = OP_MOVE;
                                n_resched = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slice_len <= SLICE_BITS'(SLICE_RESET);
            r_count     <= '0;
            r_qflag     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_slice_len <= SLICE_BITS'(i_cfg_wdata);
            end
            if (w_set_flag) begin
                r_qflag[w_idx] <= 1'b1;
            end
            if (w_clr_flag) begin
                r_qflag[w_idx] <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in_item.kind;
            r_task <= i_in_item.task_id;
        end
        if (r_state == S_EXEC) begin
            r_status    <= n_status;
            r_resched   <= n_resched;
            r_slice_out <= n_slice_out;
        end
        if (w_load_out) begin
            r_out_item.status       <= r_status;
            r_out_item.head_task    <= w_occ[0] ? w_id[0] : '0;
            r_out_item.reschedule   <= r_resched;
            r_out_item.queued_count <= 6'(r_count);
            r_out_item.slice_left   <= 16'(r_slice_out);
        end
    end

    // cell row occupancy and the queued flags both track the count
    `RRQ_ASSERT_ALWAYS(a_count_cells, $countones(w_occ) == 32'(r_count))
    `RRQ_ASSERT_ALWAYS(a_count_flags, $countones(r_qflag) == 32'(r_count))
    // a task to be removed or moved is always found in the cell row
    `RRQ_ASSERT_IMP(a_remove_hits, (w_ctl.op == OP_REMOVE) || (w_ctl.op == OP_MOVE), w_hit[MAX_TASKS-1])
    `RRQ_ASSERT_IMP(a_resched_ok, o_out_valid && o_out_item.reschedule, o_out_item.status == ST_OK)

endmodule
